@@ hw/rtl/lkpw_pkg.sv @@
// Package for the link keepalive ping watchdog.
// Holds the phase type, field widths and configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps

package lkpw_pkg;

    localparam int CNT_W     = 24;
    localparam int CLK_W     = 32;
    localparam int CFG_IDX_W = 8;

    typedef enum logic [1:0] {
        PH_SEND    = 2'd0,
        PH_WARN    = 2'd1,
        PH_TIMEOUT = 2'd2,
        PH_IDLE    = 2'd3
    } phase_t;

    localparam logic [CFG_IDX_W-1:0] CFG_PING_PERIOD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_TIME   = 8'd1;

    localparam logic [CNT_W-1:0] PING_PERIOD_RST = 24'd60000;
    localparam logic [CNT_W-1:0] WARN_TIME_RST   = 24'd15000;

    // Decoded outcome of one input beat.
    typedef struct packed {
        logic is_pong;
        logic stop;
        logic expire;
    } step_t;

    // Interval load with the minimum of one tick.
    function automatic logic [CNT_W-1:0] clamp_load(input logic [CNT_W-1:0] v);
        return (v == '0) ? CNT_W'(1) : v;
    endfunction

endpackage

@@ hw/rtl/link_keepalive_ping_watchdog_top.sv @@
// Top level of the link keepalive ping watchdog.
// Depends on lkpw_pkg for the phase type, widths and register indexes.
`timescale 1ns / 1ps

// Keepalive watchdog for one link. Every input beat is a one millisecond tick
// (op = 0) or a pong arrival (op = 1) and produces exactly one result beat in the
// cycle after it is accepted, carrying the ping, warning and close requests,
// the round-trip time of a pong and the phase after the event. One beat is
// accepted every clock cycle; the whole update is combinational between the
// accepting edge and the result register, and s_ready drops only while a
// result waits for m_ready. Writes to ping_period and warn_time are always
// accepted and take effect at the next interval load.
module link_keepalive_ping_watchdog_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic                          s_link_local,
    input  logic                          s_link_dead,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_send_ping,
    output logic                          m_latency_warning,
    output logic                          m_close_link,
    output logic                          m_rtt_valid,
    output logic [31:0]                   m_round_trip,
    output logic [1:0]                    m_phase_now,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lkpw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lkpw_pkg::CNT_W-1:0]    cfg_data
);
    import lkpw_pkg::*;

    logic [CNT_W-1:0] ping_period_reg;
    logic [CNT_W-1:0] warn_time_reg;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] countdown_reg, countdown_next;
    logic             running_reg, running_next;
    logic [CLK_W-1:0] clock_reg, clock_next;
    logic [CLK_W-1:0] ping_at_reg, ping_at_next;

    logic             out_valid_reg;
    logic             ping_reg, ping_next;
    logic             warn_reg, warn_next;
    logic             close_reg, close_next;
    logic             rtt_valid_reg, rtt_valid_next;
    logic [CLK_W-1:0] rtt_reg, rtt_next;

    logic             accept;
    step_t            step;
    logic [CNT_W-1:0] count_dec;
    logic [CNT_W-1:0] timeout_load;

    assign cfg_ready = 1'b1;
    assign s_ready   = !out_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ping_period_reg <= PING_PERIOD_RST;
            warn_time_reg   <= WARN_TIME_RST;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_PING_PERIOD) begin
                ping_period_reg <= cfg_data;
            end else if (cfg_index == CFG_WARN_TIME) begin
                warn_time_reg <= cfg_data;
            end
        end
    end

    // The countdown saturates at zero; reaching zero on a live tick is an expiry.
    assign count_dec    = (countdown_reg <= CNT_W'(1)) ? '0 : countdown_reg - CNT_W'(1);
    assign timeout_load = (warn_time_reg >= ping_period_reg) ? CNT_W'(1)
                        : clamp_load(ping_period_reg - warn_time_reg);

    always_comb begin
        step.is_pong = s_op;
        step.stop    = !s_op && s_link_dead;
        step.expire  = !s_op && !s_link_dead && running_reg && (count_dec == '0);
    end

    // Next state.
    always_comb begin
        phase_next     = phase_reg;
        countdown_next = countdown_reg;
        running_next   = running_reg;
        clock_next     = clock_reg;
        ping_at_next   = ping_at_reg;
        if (step.is_pong) begin
            phase_next     = PH_SEND;
            countdown_next = clamp_load(ping_period_reg);
            running_next   = 1'b1;
        end else begin
            clock_next = clock_reg + CLK_W'(1);
            if (step.stop) begin
                running_next = 1'b0;
            end else if (running_reg) begin
                countdown_next = count_dec;
                if (step.expire) begin
                    unique case (phase_reg)
                        PH_SEND: begin
                            ping_at_next = clock_next;
                            if (warn_time_reg != '0) begin
                                phase_next     = PH_WARN;
                                countdown_next = clamp_load(warn_time_reg);
                            end else begin
                                phase_next     = PH_TIMEOUT;
                                countdown_next = timeout_load;
                            end
                        end
                        PH_WARN: begin
                            phase_next     = PH_TIMEOUT;
                            countdown_next = timeout_load;
                        end
                        PH_TIMEOUT: begin
                            phase_next   = PH_IDLE;
                            running_next = 1'b0;
                        end
                        default: begin
                            running_next = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    // Result fields.
    always_comb begin
        ping_next      = 1'b0;
        warn_next      = 1'b0;
        close_next     = 1'b0;
        rtt_valid_next = step.is_pong;
        rtt_next       = step.is_pong ? (clock_reg - ping_at_reg) : '0;
        if (step.expire) begin
            unique case (phase_reg)
                PH_SEND:    ping_next  = 1'b1;
                PH_WARN:    warn_next  = 1'b1;
                PH_TIMEOUT: close_next = s_link_local;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SEND;
            countdown_reg <= PING_PERIOD_RST;
            running_reg   <= 1'b1;
            clock_reg     <= '0;
            ping_at_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg     <= phase_next;
                countdown_reg <= countdown_next;
                running_reg   <= running_next;
                clock_reg     <= clock_next;
                ping_at_reg   <= ping_at_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ping_reg      <= ping_next;
            warn_reg      <= warn_next;
            close_reg     <= close_next;
            rtt_valid_reg <= rtt_valid_next;
            rtt_reg       <= rtt_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_send_ping       = ping_reg;
    assign m_latency_warning = warn_reg;
    assign m_close_link      = close_reg;
    assign m_rtt_valid       = rtt_valid_reg;
    assign m_round_trip      = rtt_reg;
    assign m_phase_now       = phase_reg;

    // A ping always hands over to the warn or timeout phase.
    a_ping_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_send_ping) |-> (m_phase_now == PH_WARN || m_phase_now == PH_TIMEOUT))
        else $error("ping result not followed by warn or timeout phase");

    // A close request leaves the block idle with the timer stopped.
    a_close_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_close_link) |-> (m_phase_now == PH_IDLE && !running_reg))
        else $error("close request without idle phase");

    // A pong restarts the cycle and raises no other request.
    a_pong_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rtt_valid) |->
        (m_phase_now == PH_SEND && !m_send_ping && !m_latency_warning && !m_close_link))
        else $error("pong result with stray request or wrong phase");

    // The round-trip field is zero unless it carries a measurement.
    a_rtt_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_rtt_valid) |-> (m_round_trip == '0))
        else $error("round trip nonzero without measurement");

endmodule

@@ verif/tb_link_keepalive_ping_watchdog_top.sv @@
// Self-checking testbench for the link keepalive ping watchdog top level.
// A scoreboard class predicts every result beat from the accepted tick/pong beats.
// Depends on lkpw_pkg and link_keepalive_ping_watchdog_top.
`timescale 1ns / 1ps

module tb_link_keepalive_ping_watchdog_top;
    import lkpw_pkg::*;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_PONG = 1'b1;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int STALL_LIMIT     = 1000;
    localparam int DRAIN_CYCLES    = 8;

    typedef struct packed {
        logic         send_ping;
        logic         latency_warning;
        logic         close_link;
        logic         rtt_valid;
        logic [31:0]  round_trip;
        phase_t       phase_now;
    } outcome_t;

    class keepalive_tracker;
        logic [CNT_W-1:0] period;
        logic [CNT_W-1:0] warn;
        phase_t           phase;
        logic [CNT_W-1:0] countdown;
        bit               running;
        logic [CLK_W-1:0] ticks;
        logic [CLK_W-1:0] ping_at;
        outcome_t         pending[$];
        int unsigned      errors;

        function new();
            period    = PING_PERIOD_RST;
            warn      = WARN_TIME_RST;
            phase     = PH_SEND;
            countdown = PING_PERIOD_RST;
            running   = 1'b1;
            ticks     = '0;
            ping_at   = '0;
            errors    = 0;
        endfunction

        function logic [CNT_W-1:0] at_least_one(logic [CNT_W-1:0] v);
            return (v == '0) ? CNT_W'(1) : v;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
            if (idx == CFG_PING_PERIOD)
                period = data;
            else if (idx == CFG_WARN_TIME)
                warn = data;
        endfunction

        function void load_phase(phase_t p);
            phase   = p;
            running = 1'b1;
            case (p)
                PH_SEND: begin
                    countdown = at_least_one(period);
                end
                PH_WARN: begin
                    countdown = at_least_one(warn);
                end
                PH_TIMEOUT: begin
                    // With warnings disabled the whole period is spent here.
                    countdown = (warn >= period) ? CNT_W'(1) : at_least_one(period - warn);
                end
                default: begin
                    running = 1'b0;
                end
            endcase
        endfunction

        function bit needs_pong();
            return (phase == PH_IDLE) || !running;
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        function void note_event(logic op, logic loc, logic dead);
            outcome_t o;
            o = '0;
            if (op == OP_PONG) begin
                o.rtt_valid  = 1'b1;
                o.round_trip = ticks - ping_at;
                load_phase(PH_SEND);
            end else begin
                ticks = ticks + 1'b1;
                if (dead) begin
                    running = 1'b0;
                end else if (running) begin
                    countdown = (countdown <= 1) ? '0 : countdown - 1'b1;
                    if (countdown == '0) begin
                        case (phase)
                            PH_SEND: begin
                                o.send_ping = 1'b1;
                                ping_at     = ticks;
                                load_phase((warn != '0) ? PH_WARN : PH_TIMEOUT);
                            end
                            PH_WARN: begin
                                o.latency_warning = 1'b1;
                                load_phase(PH_TIMEOUT);
                            end
                            PH_TIMEOUT: begin
                                o.close_link = loc;
                                load_phase(PH_IDLE);
                            end
                            default: begin
                                running = 1'b0;
                            end
                        endcase
                    end
                end
            end
            o.phase_now = phase;
            pending.push_back(o);
        endfunction

        function void match_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_outcome(logic send, logic lw, logic cl, logic rv,
                                    logic [31:0] rtt, logic [1:0] ph);
            outcome_t e;
            if (pending.size() == 0) begin
                $error("result beat arrived with no pending expectation");
                errors++;
                return;
            end
            e = pending.pop_front();
            match_field("send_ping", e.send_ping, send);
            match_field("latency_warning", e.latency_warning, lw);
            match_field("close_link", e.close_link, cl);
            match_field("rtt_valid", e.rtt_valid, rv);
            match_field("round_trip", e.round_trip, rtt);
            match_field("phase_now", e.phase_now, ph);
        endfunction
    endclass

    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 s_valid      = 1'b0;
    logic                 s_op         = 1'b0;
    logic                 s_link_local = 1'b0;
    logic                 s_link_dead  = 1'b0;
    logic                 m_ready      = 1'b0;
    logic                 cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CNT_W-1:0]     cfg_data     = '0;
    logic                 s_ready;
    logic                 m_valid;
    logic                 m_send_ping;
    logic                 m_latency_warning;
    logic                 m_close_link;
    logic                 m_rtt_valid;
    logic [31:0]          m_round_trip;
    logic [1:0]           m_phase_now;
    logic                 cfg_ready;

    keepalive_tracker tracker;
    bit               src_quiet    = 1'b0;
    bit               snk_quiet    = 1'b0;
    bit               hold_off_req = 1'b0;
    int unsigned      quiet_cycles = 0;

    link_keepalive_ping_watchdog_top dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_link_local      (s_link_local),
        .s_link_dead       (s_link_dead),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_send_ping       (m_send_ping),
        .m_latency_warning (m_latency_warning),
        .m_close_link      (m_close_link),
        .m_rtt_valid       (m_rtt_valid),
        .m_round_trip      (m_round_trip),
        .m_phase_now       (m_phase_now),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Results are checked before the input of the same edge is noted; a result
    // never belongs to a beat accepted on the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                tracker.check_outcome(m_send_ping, m_latency_warning, m_close_link,
                                      m_rtt_valid, m_round_trip, m_phase_now);
            if (s_valid && s_ready)
                tracker.note_event(s_op, s_link_local, s_link_dead);
            if (cfg_valid && cfg_ready)
                tracker.write_reg(cfg_index, cfg_data);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            stall = snk_quiet ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic offer_event(input logic op, input logic loc, input logic dead);
        int gap;
        gap = src_quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_link_local <= loc;
        s_link_dead  <= dead;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic tick_run(input int count, input logic loc);
        repeat (count) offer_event(OP_TICK, loc, 1'b0);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.outstanding() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // An unmapped index is written between the real ones; it must change nothing.
    task automatic reprogram(input logic [CNT_W-1:0] period, input logic [CNT_W-1:0] warn);
        settle();
        write_reg(CFG_PING_PERIOD, period);
        write_reg(CFG_IDX_W'($urandom_range(CFG_WARN_TIME + 1, 255)), CNT_W'($urandom));
        write_reg(CFG_WARN_TIME, warn);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_events(input int count);
        logic op;
        logic dead;
        repeat (count) begin
            // A stopped or idle watchdog only moves again after a pong.
            if (tracker.needs_pong())
                op = ($urandom_range(0, 2) == 0) ? OP_PONG : OP_TICK;
            else
                op = ($urandom_range(0, 11) == 0) ? OP_PONG : OP_TICK;
            if (op == OP_PONG)
                dead = 1'($urandom);
            else
                dead = ($urandom_range(0, 19) == 0);
            offer_event(op, 1'($urandom), dead);
        end
    endtask

    initial begin : stimulus
        int seg;
        logic [CNT_W-1:0] p;
        logic [CNT_W-1:0] w;
        tracker = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: pong before any ping, dead link, stopped timer.
        offer_event(OP_PONG, 1'b0, 1'b1);
        offer_event(OP_TICK, 1'b1, 1'b1);
        offer_event(OP_TICK, 1'b1, 1'b0);
        offer_event(OP_PONG, 1'b1, 1'b0);

        // Full cycle on a local link, then a tick while idle.
        reprogram(24'd3, 24'd1);
        offer_event(OP_PONG, 1'b0, 1'b0);
        tick_run(5, 1'b0);
        tick_run(2, 1'b1);
        offer_event(OP_PONG, 1'b1, 1'b0);

        // Warnings disabled, timeout on a remote link.
        reprogram(24'd2, 24'd0);
        offer_event(OP_PONG, 1'b0, 1'b0);
        tick_run(4, 1'b0);
        offer_event(OP_PONG, 1'b0, 1'b1);

        // Warn time not below the period clamps the timeout interval to one tick.
        reprogram(24'd2, 24'd5);
        offer_event(OP_PONG, 1'b1, 1'b0);
        tick_run(7, 1'b0);
        tick_run(1, 1'b1);
        offer_event(OP_PONG, 1'b0, 1'b0);

        for (seg = 0; seg < 10; seg++) begin
            case (seg)
                0: begin p = 24'd1;        w = 24'd0;        end
                1: begin p = 24'hFFFFFF;   w = 24'hFFFFFF;   end
                2: begin p = 24'hFFFFFF;   w = 24'd0;        end
                3: begin p = 24'd1;        w = 24'hFFFFFF;   end
                default: begin
                    p = CNT_W'($urandom_range(1, 20));
                    w = CNT_W'($urandom_range(0, 24));
                end
            endcase
            reprogram(p, w);
            src_quiet = ($urandom_range(0, 2) == 0);
            snk_quiet = ($urandom_range(0, 2) == 0);
            if (seg == 5) begin
                // Keep the sender busy while the sink holds off so the block backs up.
                src_quiet    = 1'b1;
                hold_off_req = 1'b1;
            end
            random_events((seg < 4) ? 100 : 180);
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
